>>> hdl/stq_pkg.sv
// ----------------------------------------------------------------------------
// stq_pkg
// Shared types, codes and default sizes of the sparse table range query block.
// ----------------------------------------------------------------------------
package stq_pkg;

  // Default sizes
  localparam int MAX_ELEMENTS_DEF = 1024;
  localparam int LEVELS_DEF       = 11;
  localparam int DATA_WIDTH_DEF   = 32;

  // Fixed field widths of the channels
  localparam int VALUE_W  = 32;
  localparam int LEFT_W   = 10;
  localparam int RIGHT_W  = 11;
  localparam int ANSWER_W = 32;
  localparam int STATUS_W = 2;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 3;
  localparam logic REG_COMBINE_MODE = 1'b0;   // word index of combine_mode

  typedef enum logic [1:0] {
    MODE_MIN = 2'd0,
    MODE_MAX = 2'd1,
    MODE_AND = 2'd2,
    MODE_OR  = 2'd3
  } mode_t;

  localparam logic FUNC_LOAD  = 1'b0;
  localparam logic FUNC_QUERY = 1'b1;

  localparam logic [STATUS_W-1:0] STATUS_OK        = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_RANGE     = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_NOT_BUILT = 2'd2;

endpackage

>>> hdl/stq_if.sv
// ----------------------------------------------------------------------------
// stq_in_if / stq_out_if
// Valid/ready stream channels carrying query items and query results.
// ----------------------------------------------------------------------------
interface stq_in_if;
  logic                               valid;
  logic                               ready;
  logic                               func;
  logic signed [stq_pkg::VALUE_W-1:0] value;
  logic                               last_element;
  logic        [stq_pkg::LEFT_W-1:0]  left;
  logic        [stq_pkg::RIGHT_W-1:0] right;

  modport source (output valid, func, value, last_element, left, right, input ready);
  modport sink   (input valid, func, value, last_element, left, right, output ready);
endinterface

interface stq_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [stq_pkg::ANSWER_W-1:0] answer;
  logic        [stq_pkg::STATUS_W-1:0] status;

  modport source (output valid, answer, status, input ready);
  modport sink   (input valid, answer, status, output ready);
endinterface

>>> hdl/stq_ram.sv
// ----------------------------------------------------------------------------
// stq_ram
// Generic RAM: one write port, two read ports, registered read data.
// ----------------------------------------------------------------------------
module stq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr_a,
  input  logic [$clog2(DEPTH)-1:0] raddr_b,
  output logic [WIDTH-1:0]         rdata_a,
  output logic [WIDTH-1:0]         rdata_b
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    // hold read data while no read is issued
    if (re) begin
      rdata_a <= mem[raddr_a];
      rdata_b <= mem[raddr_b];
    end
  end

endmodule

>>> hdl/stq_combine.sv
// ----------------------------------------------------------------------------
// stq_combine
// Idempotent combining operator: signed min, signed max, bitwise and, or.
// ----------------------------------------------------------------------------
module stq_combine #(
  parameter int DW = 32
) (
  input  stq_pkg::mode_t  mode,
  input  logic [DW-1:0]   a,
  input  logic [DW-1:0]   b,
  output logic [DW-1:0]   y
);

  logic a_le_b;

  assign a_le_b = ($signed(a) <= $signed(b));

  always_comb begin
    unique case (mode)
      stq_pkg::MODE_MIN: y = a_le_b ? a : b;
      stq_pkg::MODE_MAX: y = a_le_b ? b : a;
      stq_pkg::MODE_AND: y = a & b;
      stq_pkg::MODE_OR:  y = a | b;
      default:           y = a;
    endcase
  end

endmodule

>>> hdl/sparse_table_range_query_top.sv
// ----------------------------------------------------------------------------
// sparse_table_range_query_top
// Sparse table for idempotent range queries, held in one dual-read RAM.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Handshake             Payload
// -------  ---  --------------------  ----------------------------------------
// in_ch    in   valid/ready           func, value, last_element, left, right
// out_ch   out  valid/ready           answer, status (one per query)
// cfg_*    in   APB write/read        combine_mode at byte address 0
//
// A load item's element is written to level 0 at the transfer edge while
// there is room. A query item reads both table entries in the transfer cycle
// through the two RAM read ports; they are then combined into the output
// register once it is free. The build after the last load walks the table
// one entry per cycle: for n elements, level j has n - 2^j + 1 entries. A drain
// state comes before level 1 and after each level, so no level reads an
// entry whose write is still in flight.
// in_ch.ready stays low during the build and while a query result waits for
// the output register. A load is taken even while a result is held.
// Reset clears the control state only; the table needs no clearing pass.
// ----------------------------------------------------------------------------
module sparse_table_range_query_top #(
  parameter int MAX_ELEMENTS = stq_pkg::MAX_ELEMENTS_DEF,
  parameter int LEVELS       = stq_pkg::LEVELS_DEF,
  parameter int DATA_WIDTH   = stq_pkg::DATA_WIDTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  stq_in_if.sink                            in_ch,
  stq_out_if.source                         out_ch,
  input  logic                              cfg_psel,
  input  logic                              cfg_penable,
  input  logic                              cfg_pwrite,
  input  logic [stq_pkg::CFG_ADDR_W-1:0]    cfg_paddr,
  input  logic [stq_pkg::CFG_DATA_W-1:0]    cfg_pwdata,
  output logic [stq_pkg::CFG_DATA_W-1:0]    cfg_prdata,
  output logic                              cfg_pready
);

  localparam int IDX_W  = $clog2(MAX_ELEMENTS);
  localparam int CNT_W  = $clog2(MAX_ELEMENTS + 1);
  localparam int LVL_W  = $clog2(LEVELS);
  localparam int LVC_W  = $clog2(LEVELS + 1);
  localparam int ADDR_W = LVL_W + IDX_W;
  localparam int DEPTH  = LEVELS * (2 ** IDX_W);
  localparam int QW     = (CNT_W > stq_pkg::RIGHT_W) ? CNT_W : stq_pkg::RIGHT_W;
  localparam int LOG_W  = $clog2(QW);
  localparam int SW     = ((LEVELS + 1) > CNT_W) ? (LEVELS + 1) : CNT_W;

  typedef enum logic [3:0] {
    ST_IDLE  = 4'b0001,
    ST_QUERY = 4'b0010,
    ST_BUILD = 4'b0100,
    ST_DRAIN = 4'b1000
  } state_t;

  // control state
  state_t                       state_r, state_nxt;
  logic [CNT_W-1:0]             cnt_r, cnt_nxt;
  logic                         ready_r, ready_nxt;
  logic [LVC_W-1:0]             lvl_r, lvl_nxt;
  logic [IDX_W-1:0]             idx_r, idx_nxt;
  stq_pkg::mode_t               bmode_r, bmode_nxt;
  stq_pkg::mode_t               mode_r, mode_nxt;
  logic                         pipe_v_r, pipe_v_nxt;
  logic                         out_valid_r, out_valid_nxt;

  // payload
  logic [ADDR_W-1:0]            pipe_addr_r, pipe_addr_nxt;
  logic [stq_pkg::STATUS_W-1:0] qstat_r, qstat_nxt;
  logic [stq_pkg::ANSWER_W-1:0] answer_r, answer_nxt;
  logic [stq_pkg::STATUS_W-1:0] status_r, status_nxt;

  // RAM and combiner
  logic                         ram_we, ram_re;
  logic [ADDR_W-1:0]            ram_waddr, ram_raddr_a, ram_raddr_b;
  logic [DATA_WIDTH-1:0]        ram_wdata, rd_a, rd_b, comb_y;
  stq_pkg::mode_t               comb_mode;

  // handshake
  logic                         in_xfer, load_xfer, query_xfer, cfg_wr;

  // query decode
  logic [QW-1:0]                left_q, right_q, cnt_q, len_q;
  logic [LOG_W-1:0]             lg;
  logic [LVL_W-1:0]             qlvl;
  logic [QW-1:0]                qidx_b;
  logic [stq_pkg::STATUS_W-1:0] qstat_in;

  // load decode
  logic [CNT_W-1:0]             eff_cnt;
  logic                         room;

  // build decode
  logic [SW-1:0]                span_b, half_b, cnt_s, idx_s, idx_b;
  logic [LVC_W-1:0]             lvl_prev;

  assign in_ch.ready = (state_r == ST_IDLE);
  assign in_xfer     = in_ch.valid && in_ch.ready;
  assign load_xfer   = in_xfer && (in_ch.func == stq_pkg::FUNC_LOAD);
  assign query_xfer  = in_xfer && (in_ch.func == stq_pkg::FUNC_QUERY);

  assign out_ch.valid  = out_valid_r;
  assign out_ch.answer = answer_r;
  assign out_ch.status = status_r;

  // ---------------------------------------------------------------------------
  // Configuration port: single register, writes ignored beyond its word
  // ---------------------------------------------------------------------------
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_comb begin
    mode_nxt = mode_r;
    if (cfg_wr && (cfg_paddr[2] == stq_pkg::REG_COMBINE_MODE)) begin
      mode_nxt = stq_pkg::mode_t'(cfg_pwdata[1:0]);
    end
  end

  always_comb begin
    cfg_prdata = '0;
    if (cfg_paddr[2] == stq_pkg::REG_COMBINE_MODE) begin
      cfg_prdata = {{(stq_pkg::CFG_DATA_W - 2){1'b0}}, mode_r};
    end
  end

  // ---------------------------------------------------------------------------
  // Query decode: level = floor(log2(right - left)), clamped to the top level
  // ---------------------------------------------------------------------------
  assign left_q  = QW'(in_ch.left);
  assign right_q = QW'(in_ch.right);
  assign cnt_q   = QW'(cnt_r);
  assign len_q   = right_q - left_q;

  always_comb begin
    lg = '0;
    for (int b = 0; b < QW; b++) begin
      if (len_q[b]) begin
        lg = LOG_W'(b);
      end
    end
  end

  always_comb begin
    if (int'(lg) > LEVELS - 1) begin
      qlvl = LVL_W'(LEVELS - 1);
    end else begin
      qlvl = LVL_W'(lg);
    end
  end

  // second entry starts 2^level before the right end
  assign qidx_b = right_q - (QW'(1) << qlvl);

  always_comb begin
    priority if (!ready_r) begin
      qstat_in = stq_pkg::STATUS_NOT_BUILT;
    end else if ((left_q >= right_q) || (right_q > cnt_q)) begin
      qstat_in = stq_pkg::STATUS_RANGE;
    end else begin
      qstat_in = stq_pkg::STATUS_OK;
    end
  end

  // ---------------------------------------------------------------------------
  // Load decode: a load after a build restarts the array
  // ---------------------------------------------------------------------------
  assign eff_cnt = ready_r ? '0 : cnt_r;
  assign room    = (eff_cnt < CNT_W'(MAX_ELEMENTS));

  // ---------------------------------------------------------------------------
  // Build decode
  // ---------------------------------------------------------------------------
  assign span_b   = SW'(1) << lvl_r;
  assign half_b   = span_b >> 1;
  assign cnt_s    = SW'(cnt_r);
  assign idx_s    = SW'(idx_r);
  assign idx_b    = idx_s + half_b;
  assign lvl_prev = lvl_r - LVC_W'(1);

  // ---------------------------------------------------------------------------
  // RAM ports: build writes and load writes never share a cycle
  // ---------------------------------------------------------------------------
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = pipe_addr_r;
    ram_wdata = comb_y;
    if (pipe_v_r) begin
      ram_we = 1'b1;
    end else if (load_xfer && room) begin
      ram_we    = 1'b1;
      ram_waddr = {LVL_W'(0), eff_cnt[IDX_W-1:0]};
      ram_wdata = DATA_WIDTH'(in_ch.value);
    end
  end

  always_comb begin
    ram_re      = 1'b0;
    ram_raddr_a = {qlvl, left_q[IDX_W-1:0]};
    ram_raddr_b = {qlvl, qidx_b[IDX_W-1:0]};
    if (state_r == ST_BUILD) begin
      ram_re      = 1'b1;
      ram_raddr_a = {lvl_prev[LVL_W-1:0], idx_r};
      ram_raddr_b = {lvl_prev[LVL_W-1:0], idx_b[IDX_W-1:0]};
    end else if (query_xfer) begin
      ram_re = 1'b1;
    end
  end

  stq_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (DEPTH)
  ) u_table (
    .clk     (clk),
    .we      (ram_we),
    .waddr   (ram_waddr),
    .wdata   (ram_wdata),
    .re      (ram_re),
    .raddr_a (ram_raddr_a),
    .raddr_b (ram_raddr_b),
    .rdata_a (rd_a),
    .rdata_b (rd_b)
  );

  // queries use the current mode, the build keeps the mode it started with
  assign comb_mode = (state_r == ST_QUERY) ? mode_r : bmode_r;

  stq_combine #(
    .DW (DATA_WIDTH)
  ) u_combine (
    .mode (comb_mode),
    .a    (rd_a),
    .b    (rd_b),
    .y    (comb_y)
  );

  // ---------------------------------------------------------------------------
  // Sequencer
  // ---------------------------------------------------------------------------
  always_comb begin
    state_nxt     = state_r;
    cnt_nxt       = cnt_r;
    ready_nxt     = ready_r;
    lvl_nxt       = lvl_r;
    idx_nxt       = idx_r;
    bmode_nxt     = bmode_r;
    pipe_v_nxt    = 1'b0;
    pipe_addr_nxt = pipe_addr_r;
    qstat_nxt     = qstat_r;
    out_valid_nxt = out_valid_r && !out_ch.ready;
    answer_nxt    = answer_r;
    status_nxt    = status_r;

    unique case (state_r)
      ST_IDLE: begin
        if (load_xfer) begin
          ready_nxt = 1'b0;
          cnt_nxt   = eff_cnt + CNT_W'(room);
          if (in_ch.last_element) begin
            // start the build at level 1 after the drain state
            state_nxt = ST_DRAIN;
            lvl_nxt   = LVC_W'(1);
            idx_nxt   = '0;
            bmode_nxt = mode_r;
          end
        end else if (query_xfer) begin
          state_nxt = ST_QUERY;
          qstat_nxt = qstat_in;
        end
      end

      ST_QUERY: begin
        // hold the read data until the output register frees up
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          status_nxt    = qstat_r;
          answer_nxt    = (qstat_r == stq_pkg::STATUS_OK) ?
                          stq_pkg::ANSWER_W'(signed'(comb_y)) : '0;
          state_nxt     = ST_IDLE;
        end
      end

      ST_BUILD: begin
        pipe_v_nxt    = 1'b1;
        pipe_addr_nxt = {lvl_r[LVL_W-1:0], idx_r};
        if (idx_s + span_b == cnt_s) begin
          state_nxt = ST_DRAIN;
          lvl_nxt   = lvl_r + LVC_W'(1);
          idx_nxt   = '0;
        end else begin
          idx_nxt = idx_r + IDX_W'(1);
        end
      end

      ST_DRAIN: begin
        // the last write of the previous level lands in this cycle
        if ((lvl_r == LVC_W'(LEVELS)) || (span_b > cnt_s)) begin
          state_nxt = ST_IDLE;
          ready_nxt = 1'b1;
        end else begin
          state_nxt = ST_BUILD;
        end
      end

      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      cnt_r       <= '0;
      ready_r     <= 1'b0;
      lvl_r       <= '0;
      idx_r       <= '0;
      bmode_r     <= stq_pkg::MODE_MIN;
      mode_r      <= stq_pkg::MODE_MIN;
      pipe_v_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      ready_r     <= ready_nxt;
      lvl_r       <= lvl_nxt;
      idx_r       <= idx_nxt;
      bmode_r     <= bmode_nxt;
      mode_r      <= mode_nxt;
      pipe_v_r    <= pipe_v_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    pipe_addr_r <= pipe_addr_nxt;
    qstat_r     <= qstat_nxt;
    answer_r    <= answer_nxt;
    status_r    <= status_nxt;
  end

endmodule

>>> bench/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the sparse table range query block. Loads signed
// arrays, lets the block build its table, fires range queries under all four
// combine modes, and checks every result against a cycle-free predictor.
// ----------------------------------------------------------------------------
module testbench;
  import stq_pkg::*;

  localparam int NMAX = MAX_ELEMENTS_DEF;
  localparam int NLVL = LEVELS_DEF;
  localparam int DW   = DATA_WIDTH_DEF;
  localparam logic [CFG_ADDR_W-1:0] MODE_ADDR = CFG_ADDR_W'(4 * int'(REG_COMBINE_MODE));

  typedef struct packed {
    logic                       func;
    logic signed [VALUE_W-1:0]  value;
    logic                       last_element;
    logic        [LEFT_W-1:0]   left;
    logic        [RIGHT_W-1:0]  right;
  } query_item_t;

  typedef struct packed {
    logic signed [ANSWER_W-1:0] answer;
    logic        [STATUS_W-1:0] status;
  } answer_t;

  // --------------------------------------------------------------------------
  // Range combiner: own copy of the sparse table, element count, built flag
  // and combine mode; predicts one answer per query transfer.
  // --------------------------------------------------------------------------
  class range_combiner;
    logic signed [DW-1:0] lvl [NLVL][NMAX];
    int                   count;
    bit                   built;
    mode_t                mode;
    answer_t              awaited_answers[$];
    int                   mismatches;

    function new();
      count      = 0;
      built      = 1'b0;
      mode       = MODE_MIN;
      mismatches = 0;
    endfunction

    function void set_mode(mode_t m);
      mode = m;
    endfunction

    function int pending();
      return awaited_answers.size();
    endfunction

    task flag_mismatch(string msg);
      $display("%0t ns: mismatch: %s", $time, msg);
      mismatches++;
    endtask

    function logic signed [DW-1:0] merge(logic signed [DW-1:0] a, logic signed [DW-1:0] b);
      case (mode)
        MODE_MIN: return (a <= b) ? a : b;
        MODE_MAX: return (a >= b) ? a : b;
        MODE_AND: return a & b;
        default:  return a | b;
      endcase
    endfunction

    function void build_levels();
      int span;
      for (int j = 1; j < NLVL; j++) begin
        span = 1 << j;
        if (span > count) break;
        for (int i = 0; i + span <= count; i++)
          lvl[j][i] = merge(lvl[j-1][i], lvl[j-1][i + span/2]);
      end
      built = 1'b1;
    endfunction

    function void take_item(query_item_t it);
      answer_t exp;
      int      lo, hi, len, j;
      if (it.func == FUNC_LOAD) begin
        if (built) begin
          built = 1'b0;
          count = 0;
        end
        if (count < NMAX) begin
          lvl[0][count] = it.value;
          count++;
        end
        if (it.last_element) build_levels();
        return;
      end
      lo = int'(it.left);
      hi = int'(it.right);
      exp.answer = '0;
      if (!built) begin
        exp.status = STATUS_NOT_BUILT;
      end else if (lo >= hi || hi > count) begin
        exp.status = STATUS_RANGE;
      end else begin
        len = hi - lo;
        j = 0;
        while ((len >> (j + 1)) != 0) j++;
        if (j > NLVL - 1) j = NLVL - 1;
        exp.answer = merge(lvl[j][lo], lvl[j][hi - (1 << j)]);
        exp.status = STATUS_OK;
      end
      awaited_answers.push_back(exp);
    endfunction

    task check_answer(answer_t got);
      answer_t exp;
      if (awaited_answers.size() == 0) begin
        flag_mismatch($sformatf("unexpected result answer=%0d status=%0d",
                                got.answer, got.status));
        return;
      end
      exp = awaited_answers.pop_front();
      if (got.answer !== exp.answer)
        flag_mismatch($sformatf("answer %0d, expected %0d", got.answer, exp.answer));
      if (got.status !== exp.status)
        flag_mismatch($sformatf("status %0d, expected %0d", got.status, exp.status));
    endtask
  endclass

  // --------------------------------------------------------------------------
  // Clock, reset, channels, block
  // --------------------------------------------------------------------------
  logic clk = 1'b0;
  logic rst_n;

  logic                  cfg_psel;
  logic                  cfg_penable;
  logic                  cfg_pwrite;
  logic [CFG_ADDR_W-1:0] cfg_paddr;
  logic [CFG_DATA_W-1:0] cfg_pwdata;
  logic [CFG_DATA_W-1:0] cfg_prdata;
  logic                  cfg_pready;

  stq_in_if  in_ch ();
  stq_out_if out_ch ();

  range_combiner book;

  int burst_left;      // transfers left before the next sender gap
  int random_items;    // random-phase transfers counted toward the run length
  bit counting;        // count transfers of the random phase

  always #2 clk = ~clk;

  sparse_table_range_query_top uut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_ch),
    .out_ch      (out_ch),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  // --------------------------------------------------------------------------
  // Result side: stall on a randomly chosen pattern held for a random span,
  // sample every result transfer at the rising edge
  // --------------------------------------------------------------------------
  int stall_style;
  int stall_span;
  int rx_tick;

  initial begin
    out_ch.ready = 1'b0;
    stall_style  = 0;
    stall_span   = 0;
    rx_tick      = 0;
  end

  always @(negedge clk) begin
    rx_tick++;
    if (stall_span == 0) begin
      stall_style = $urandom_range(0, 3);
      stall_span  = $urandom_range(20, 200);
    end else begin
      stall_span--;
    end
    case (stall_style)
      0:       out_ch.ready <= 1'b1;                       // no stalls
      1:       out_ch.ready <= 1'($urandom_range(0, 1));   // coin flip
      2:       out_ch.ready <= (rx_tick % 5) != 0;         // short periodic stall
      default: out_ch.ready <= (rx_tick % 11) >= 7;        // long stalls
    endcase
  end

  always @(posedge clk) begin
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1)
      book.check_answer('{answer: out_ch.answer, status: out_ch.status});
  end

  // --------------------------------------------------------------------------
  // Helpers
  // --------------------------------------------------------------------------
  function automatic query_item_t load_of(logic signed [VALUE_W-1:0] v, bit last);
    query_item_t it;
    it              = '0;
    it.func         = FUNC_LOAD;
    it.value        = v;
    it.last_element = last;
    it.left         = LEFT_W'($urandom);
    it.right        = RIGHT_W'($urandom);
    return it;
  endfunction

  function automatic query_item_t query_of(int lo, int hi);
    query_item_t it;
    it              = '0;
    it.func         = FUNC_QUERY;
    it.value        = VALUE_W'($urandom);
    it.last_element = 1'($urandom_range(0, 1));
    it.left         = LEFT_W'(lo);
    it.right        = RIGHT_W'(hi);
    return it;
  endfunction

  // Mostly well-formed range over the current array, sometimes of power-of-two length
  function automatic query_item_t range_query(int n);
    int lo, hi, k;
    if (n < 1 || $urandom_range(0, 9) == 0)
      return query_of($urandom_range(0, NMAX - 1), $urandom_range(0, NMAX));
    lo = $urandom_range(0, n - 1);
    if ($urandom_range(0, 4) == 0) begin
      k = 0;
      while ((1 << (k + 1)) <= n - lo) k++;
      hi = lo + (1 << $urandom_range(0, k));
    end else begin
      hi = $urandom_range(lo + 1, n);
    end
    return query_of(lo, hi);
  endfunction

  // Mix extremes, small values (ties) and dense or sparse bit patterns
  function automatic logic signed [VALUE_W-1:0] pick_value();
    logic signed [VALUE_W-1:0] extremes [4];
    extremes = '{32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh0, -32'sh1};
    case ($urandom_range(0, 9))
      0:       return extremes[$urandom_range(0, 3)];
      1, 2:    return VALUE_W'($signed($urandom_range(0, 16)) - 8);
      3:       return $urandom | $urandom | $urandom;
      4:       return $urandom & $urandom & $urandom;
      default: return $urandom;
    endcase
  endfunction

  function automatic int build_cycles(int n);
    int total;
    total = 0;
    for (int j = 1; j < NLVL; j++)
      if ((1 << j) <= n) total += n - (1 << j) + 2;
    return total;
  endfunction

  // Drive one item and hold it until the transfer; then open a gap or not
  task automatic send_item(query_item_t it);
    int gap;
    @(negedge clk);
    in_ch.valid        <= 1'b1;
    in_ch.func         <= it.func;
    in_ch.value        <= it.value;
    in_ch.last_element <= it.last_element;
    in_ch.left         <= it.left;
    in_ch.right        <= it.right;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    book.take_item(it);
    if (counting) random_items++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(40, 120)
                                               : $urandom_range(0, 15);
      gap = $urandom_range(1, 8);
      @(negedge clk);
      in_ch.valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
  endtask

  task automatic apb_xfer(input logic wr, input logic [CFG_DATA_W-1:0] wdata,
                          output logic [CFG_DATA_W-1:0] rdata);
    @(negedge clk);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= wr;
    cfg_paddr   <= MODE_ADDR;
    cfg_pwdata  <= wdata;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (cfg_pready !== 1'b1);
    rdata = cfg_prdata;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
  endtask

  // Write the combine mode, then read it back
  task automatic set_mode(mode_t m);
    logic [CFG_DATA_W-1:0] rd;
    apb_xfer(1'b1, CFG_DATA_W'(m), rd);
    book.set_mode(m);
    apb_xfer(1'b0, '0, rd);
    if (rd !== CFG_DATA_W'(m))
      book.flag_mismatch($sformatf("combine_mode reads %0h, expected %0h", rd, m));
  endtask

  // Drop valid, drain all answers, then allow a table build to finish
  task automatic settle();
    @(negedge clk);
    in_ch.valid <= 1'b0;
    while (book.pending() != 0) @(posedge clk);
    repeat (build_cycles(book.count) + 16) @(posedge clk);
  endtask

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  initial begin
    int n, nq, kind, phase;
    book = new();
    in_ch.valid        = 1'b0;
    in_ch.func         = FUNC_LOAD;
    in_ch.value        = '0;
    in_ch.last_element = 1'b0;
    in_ch.left         = '0;
    in_ch.right        = '0;
    cfg_psel           = 1'b0;
    cfg_penable        = 1'b0;
    cfg_pwrite         = 1'b0;
    cfg_paddr          = '0;
    cfg_pwdata         = '0;
    burst_left         = 0;
    random_items       = 0;
    counting           = 1'b0;
    rst_n              = 1'b0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Query before any build; a last mark on a query changes nothing
    send_item(query_of(0, 1));
    send_item(query_of(0, 1024));

    // Value extremes, last mark builds the table (mode is min after reset)
    send_item(load_of(32'sh7FFF_FFFF, 1'b0));
    send_item(load_of(32'sh8000_0000, 1'b0));
    send_item(load_of(32'sh0, 1'b0));
    send_item(load_of(-32'sh1, 1'b0));
    send_item(load_of(32'sh5, 1'b1));

    // Full, single, inner and power-of-two ranges; empty and out-of-range
    send_item(query_of(0, 5));
    send_item(query_of(0, 1));
    send_item(query_of(4, 5));
    send_item(query_of(1, 3));
    send_item(query_of(0, 4));
    send_item(query_of(2, 2));
    send_item(query_of(4, 3));
    send_item(query_of(0, 6));
    send_item(query_of(1023, 1024));

    // Change mode after the build: table keeps min, queries combine with max
    settle();
    set_mode(MODE_MAX);
    send_item(query_of(0, 5));
    send_item(query_of(1, 4));

    // Load after a build starts a fresh array of one element
    send_item(load_of(32'sh7, 1'b1));
    send_item(query_of(0, 1));
    send_item(query_of(0, 2));

    // Random phases: mostly load-then-query, some query-only, some noise
    counting = 1'b1;
    phase    = 0;
    while (random_items < 1050) begin
      settle();
      set_mode(phase < 4 ? mode_t'(phase) : mode_t'($urandom_range(0, 3)));
      kind = $urandom_range(0, 9);
      if (phase == 6) begin
        // Fill past capacity; excess elements are dropped, the mark still builds
        for (int i = 0; i < NMAX + 6; i++)
          send_item(load_of(pick_value(), i == NMAX + 5));
        send_item(query_of(0, NMAX));
        send_item(query_of(NMAX - 1, NMAX));
        send_item(query_of(0, NMAX - 1));
        send_item(query_of(NMAX / 2, NMAX));
        send_item(query_of(1, NMAX));
        repeat (30) send_item(range_query(NMAX));
      end else if (kind < 7) begin
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(49, 300) : $urandom_range(1, 48);
        for (int i = 0; i < n; i++)
          send_item(load_of(pick_value(), i == n - 1));
        nq = $urandom_range(4, (2 * n + 4 < 60) ? 2 * n + 4 : 60);
        repeat (nq) send_item(range_query(n));
      end else if (kind < 9) begin
        // Query the table built earlier under a possibly different mode
        repeat ($urandom_range(4, 24)) send_item(range_query(book.built ? book.count : 0));
      end else begin
        // Noise: loose loads, stray marks, queries on unbuilt or short arrays
        repeat ($urandom_range(8, 24)) begin
          if ($urandom_range(0, 1) == 0)
            send_item(load_of(pick_value(), $urandom_range(0, 9) == 0));
          else
            send_item(query_of($urandom_range(0, NMAX - 1), $urandom_range(0, NMAX)));
        end
      end
      phase++;
    end

    settle();
    if (book.mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #4_000_000;
    $display("FAILED: results differ");
    $finish;
  end

endmodule
